FILE: rtl/nwm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Noise window monitor package
// Shared widths, register indexes, matrix commands and item types.
// ----------------------------------------------------------------------------
package nwm_pkg;

	localparam int WINDOW  = 10;
	localparam int CODE_W  = 12;
	localparam int SUM_W   = 18;
	localparam int TIME_W  = 32;
	localparam int COLOR_W = 24;
	localparam int DATA_W  = 32;

	localparam logic [SUM_W-1:0] MAX_SUM = SUM_W'(WINDOW * ((1 << CODE_W) - 1));

	localparam logic [SUM_W-1:0]   RST_SUM_LOW  = SUM_W'(20108);
	localparam logic [SUM_W-1:0]   RST_SUM_HIGH = SUM_W'(20604);
	localparam logic [TIME_W-1:0]  RST_TIMEOUT  = TIME_W'(5000);
	localparam logic [COLOR_W-1:0] RST_COLOR    = COLOR_W'(24'hFF0000);

	typedef enum logic [1:0] {
		REG_SUM_LOW  = 2'd0,
		REG_SUM_HIGH = 2'd1,
		REG_TIMEOUT  = 2'd2,
		REG_COLOR    = 2'd3
	} reg_index_t;

	typedef enum logic [1:0] {
		CMD_NONE  = 2'd0,
		CMD_LIT   = 2'd1,
		CMD_BLACK = 2'd2
	} matrix_cmd_t;

	typedef struct packed {
		logic [CODE_W-1:0] adc_code;
		logic              button_pressed;
		logic [TIME_W-1:0] now_ms;
	} sample_t;

	typedef struct packed {
		logic [SUM_W-1:0]   window_sum;
		logic               loud;
		logic               buzzer_on;
		matrix_cmd_t        matrix_command;
		logic [COLOR_W-1:0] matrix_color;
	} result_t;

	typedef struct packed {
		logic [SUM_W-1:0]  window_sum;
		logic              button_pressed;
		logic [TIME_W-1:0] now_ms;
	} summed_t;

	typedef struct packed {
		logic [SUM_W-1:0]   sum_low_limit;
		logic [SUM_W-1:0]   sum_high_limit;
		logic [TIME_W-1:0]  quiet_timeout_ms;
		logic [COLOR_W-1:0] lit_color;
	} config_t;

endpackage
`default_nettype wire

FILE: rtl/nwm_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Noise window monitor sample cell
// Holds one code of the window and hands it to the next cell on every item.
// ----------------------------------------------------------------------------
module nwm_cell (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      shift,
	input  wire logic [nwm_pkg::CODE_W-1:0] code_in,
	output logic      [nwm_pkg::CODE_W-1:0] code_out
);

	logic [nwm_pkg::CODE_W-1:0] code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q <= '0;
		end else if (shift) begin
			code_q <= code_in;
		end
	end

	assign code_out = code_q;

endmodule
`default_nettype wire

FILE: rtl/nwm_judge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Noise window monitor decision stage
// Compares the window sum with the limits, tracks level changes and the
// quiet timeout, and registers the result item.
// ----------------------------------------------------------------------------
module nwm_judge (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire nwm_pkg::summed_t summed,
	input  wire nwm_pkg::config_t cfg,
	output nwm_pkg::result_t      result
);

	logic                        prev_loud_q;
	logic                        level_known_q;
	logic [nwm_pkg::TIME_W-1:0]  last_change_q;
	nwm_pkg::result_t            result_s2;

	logic                        loud;
	logic                        change;
	logic [nwm_pkg::TIME_W-1:0]  elapsed;
	nwm_pkg::matrix_cmd_t        cmd;
	logic [nwm_pkg::COLOR_W-1:0] color;

	always_comb begin
		loud = (summed.window_sum < cfg.sum_low_limit) ||
			(summed.window_sum > cfg.sum_high_limit);
		change = !level_known_q || (loud != prev_loud_q);
		elapsed = summed.now_ms - last_change_q;
		priority if (change) begin
			cmd = nwm_pkg::CMD_LIT;
			color = cfg.lit_color;
		end else if (elapsed > cfg.quiet_timeout_ms) begin
			cmd = nwm_pkg::CMD_BLACK;
			color = '0;
		end else begin
			cmd = nwm_pkg::CMD_NONE;
			color = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_loud_q <= 1'b0;
			level_known_q <= 1'b0;
			last_change_q <= '0;
		end else if (load) begin
			prev_loud_q <= loud;
			level_known_q <= 1'b1;
			if (change) begin
				last_change_q <= summed.now_ms;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_s2.window_sum <= summed.window_sum;
			result_s2.loud <= loud;
			result_s2.buzzer_on <= loud && !summed.button_pressed;
			result_s2.matrix_command <= cmd;
			result_s2.matrix_color <= color;
		end
	end

	assign result = result_s2;

endmodule
`default_nettype wire

FILE: rtl/noise_window_monitor.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Noise window monitor
// Moving-window sum of microphone codes with a loudness window, buzzer
// control and LED matrix commands.
// ----------------------------------------------------------------------------
// Each sample item carries a converter code, the mute button level and a
// millisecond timestamp. Each accepted sample gives exactly one result item
// with the window sum, the loud flag, the buzzer level and a matrix command.
// The last WINDOW codes sit in a row of cells that shift by one on every
// accepted sample; the code leaving the last cell is taken off the running
// sum while the new code is added.
// An accepted sample is registered in the sum stage, then loaded into the
// decision register, where its result item becomes valid. One sample is
// accepted per cycle while results are taken, so the throughput is one item
// per cycle; the sum register and the decision register form the two stages.
// Reset clears the cells, the running sum and the level history, so the
// first sample always counts as a level change and lights the matrix; the
// registers return to their default limits, timeout and color.
// When the receiver stalls, the result holds and one more sample may enter
// the sum stage; after that sample_stall rises until the result is taken.
// The user must write registers (cfg_we, cfg_index, cfg_data) only while idle; not enforced.
// ----------------------------------------------------------------------------
module noise_window_monitor (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        sample_valid,
	output logic                             sample_stall,
	input  wire nwm_pkg::sample_t            sample,
	output logic                             result_valid,
	input  wire logic                        result_stall,
	output nwm_pkg::result_t                 result,
	input  wire logic                        cfg_we,
	input  wire nwm_pkg::reg_index_t         cfg_index,
	input  wire logic [nwm_pkg::DATA_W-1:0]  cfg_data
);

	nwm_pkg::config_t            cfg_q;
	nwm_pkg::summed_t            summed_s1;
	logic                        valid_s1;
	logic                        valid_s2;
	logic                        accept;
	logic                        take;
	logic                        load;
	logic [nwm_pkg::CODE_W-1:0]  tap [nwm_pkg::WINDOW];
	logic [nwm_pkg::CODE_W-1:0]  oldest;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sum_low_limit <= nwm_pkg::RST_SUM_LOW;
			cfg_q.sum_high_limit <= nwm_pkg::RST_SUM_HIGH;
			cfg_q.quiet_timeout_ms <= nwm_pkg::RST_TIMEOUT;
			cfg_q.lit_color <= nwm_pkg::RST_COLOR;
		end else if (cfg_we) begin
			unique case (cfg_index)
				nwm_pkg::REG_SUM_LOW: begin
					cfg_q.sum_low_limit <= cfg_data[nwm_pkg::SUM_W-1:0];
				end
				nwm_pkg::REG_SUM_HIGH: begin
					cfg_q.sum_high_limit <= cfg_data[nwm_pkg::SUM_W-1:0];
				end
				nwm_pkg::REG_TIMEOUT: begin
					cfg_q.quiet_timeout_ms <= cfg_data[nwm_pkg::TIME_W-1:0];
				end
				nwm_pkg::REG_COLOR: begin
					cfg_q.lit_color <= cfg_data[nwm_pkg::COLOR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign take = valid_s2 && !result_stall;
	assign load = valid_s1 && (!valid_s2 || take);
	assign sample_stall = valid_s1 && !load;
	assign accept = sample_valid && !sample_stall;

	for (genvar i = 0; i < nwm_pkg::WINDOW; i++) begin : g_cell
		if (i == 0) begin : g_first
			nwm_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift    (accept),
				.code_in  (sample.adc_code),
				.code_out (tap[i])
			);
		end else begin : g_next
			nwm_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift    (accept),
				.code_in  (tap[i-1]),
				.code_out (tap[i])
			);
		end
	end

	assign oldest = tap[nwm_pkg::WINDOW-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			summed_s1 <= '0;
		end else if (accept) begin
			summed_s1.window_sum <= summed_s1.window_sum
				- {{(nwm_pkg::SUM_W-nwm_pkg::CODE_W){1'b0}}, oldest}
				+ {{(nwm_pkg::SUM_W-nwm_pkg::CODE_W){1'b0}}, sample.adc_code};
			summed_s1.button_pressed <= sample.button_pressed;
			summed_s1.now_ms <= sample.now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (load) begin
				valid_s1 <= 1'b0;
			end
			if (load) begin
				valid_s2 <= 1'b1;
			end else if (take) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	nwm_judge u_judge (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.summed (summed_s1),
		.cfg    (cfg_q),
		.result (result)
	);

	assign result_valid = valid_s2;

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> (valid_s1 && valid_s2 && result_stall))
		else $error("sample stall raised while the pipeline can move");

	a_sum_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		summed_s1.window_sum <= nwm_pkg::MAX_SUM)
		else $error("running sum exceeds the largest window sum");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted sample lost before the sum stage");

	a_quiet_color: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.matrix_command != nwm_pkg::CMD_LIT)
		|-> (result.matrix_color == '0))
		else $error("matrix color set without a lit command");

endmodule
`default_nettype wire
